>>> rtl/rrc_pkg.sv
package rrc_pkg;

	localparam int CODE_W     = 4;
	localparam int TARGET_W   = 16;
	localparam int READING_W  = 14;
	localparam int PAUSE_W    = 2;
	localparam int TIMEOUT_W  = 20;
	localparam int DEADBAND_W = 10;
	localparam int RELAY_W    = 4;
	// Wide enough for 36 * reading and 10 * (target + deadband).
	localparam int SCALED_W   = 21;

	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 1'b1;

	localparam logic [TIMEOUT_W-1:0]  IDLE_TIMEOUT_RST = 20'd100000;
	localparam logic [DEADBAND_W-1:0] DEADBAND_RST     = 10'd100;

	localparam logic [CODE_W-1:0] MODE_SLEEP    = 4'd0;
	localparam logic [CODE_W-1:0] MODE_CW       = 4'd1;
	localparam logic [CODE_W-1:0] MODE_CCW      = 4'd2;
	localparam logic [CODE_W-1:0] MODE_STOP_AZ  = 4'd3;
	localparam logic [CODE_W-1:0] MODE_UP       = 4'd4;
	localparam logic [CODE_W-1:0] MODE_DOWN     = 4'd5;
	localparam logic [CODE_W-1:0] MODE_STOP_EL  = 4'd6;
	localparam logic [CODE_W-1:0] MODE_STOP_ALL = 4'd7;
	localparam logic [CODE_W-1:0] MODE_TRACK    = 4'd8;

	localparam int RB_CW   = 0;
	localparam int RB_CCW  = 1;
	localparam int RB_UP   = 2;
	localparam int RB_DOWN = 3;

	localparam logic [PAUSE_W-1:0] PAUSE_NONE  = 2'd0;
	localparam logic [PAUSE_W-1:0] PAUSE_SHORT = 2'd1;
	localparam logic [PAUSE_W-1:0] PAUSE_LONG  = 2'd2;

	typedef struct packed {
		logic [CODE_W-1:0]   mode;
		logic [CODE_W-1:0]   prev_mode;
		logic [RELAY_W-1:0]  relays;
		logic                tracking;
		logic [TARGET_W-1:0] target;
	} rrc_state_t;

	typedef struct packed {
		logic [RELAY_W-1:0] relays;
		logic [CODE_W-1:0]  mode;
		logic               tracking;
		logic [PAUSE_W-1:0] pause;
	} rrc_result_t;

endpackage

>>> rtl/rrc_in_if.sv
interface rrc_in_if import rrc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 new_command;
	logic [CODE_W-1:0]    command_code;
	logic [TARGET_W-1:0]  target_elevation;
	logic                 emergency_stop;
	logic [READING_W-1:0] elevation_reading;

	modport source (
		output valid, new_command, command_code, target_elevation,
		       emergency_stop, elevation_reading,
		input  ready
	);

	modport sink (
		input  valid, new_command, command_code, target_elevation,
		       emergency_stop, elevation_reading,
		output ready
	);
endinterface

>>> rtl/rrc_out_if.sv
interface rrc_out_if import rrc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               relay_cw;
	logic               relay_ccw;
	logic               relay_up;
	logic               relay_down;
	logic [CODE_W-1:0]  current_mode;
	logic               tracking_active;
	logic [PAUSE_W-1:0] pause_code;

	modport source (
		output valid, relay_cw, relay_ccw, relay_up, relay_down, current_mode,
		       tracking_active, pause_code,
		input  ready
	);

	modport sink (
		input  valid, relay_cw, relay_ccw, relay_up, relay_down, current_mode,
		       tracking_active, pause_code,
		output ready
	);
endinterface

>>> rtl/rrc_step.sv
module rrc_step import rrc_pkg::*; #(
	parameter int COUNTER_BITS = 20
) (
	input  rrc_state_t              st_cur,
	input  logic [COUNTER_BITS-1:0] idle_cur,
	input  logic [TIMEOUT_W-1:0]    idle_timeout,
	input  logic [DEADBAND_W-1:0]   deadband,
	input  logic                    new_command,
	input  logic [CODE_W-1:0]       command_code,
	input  logic [TARGET_W-1:0]     target_elevation,
	input  logic                    emergency_stop,
	input  logic [READING_W-1:0]    elevation_reading,
	output rrc_state_t              st_nxt,
	output logic [COUNTER_BITS-1:0] idle_nxt,
	output rrc_result_t             res
);

	localparam int CMP_W = (COUNTER_BITS > TIMEOUT_W) ? COUNTER_BITS : TIMEOUT_W;

	rrc_state_t              st;
	logic [COUNTER_BITS-1:0] idle;
	logic [PAUSE_W-1:0]      pause;
	logic [SCALED_W-1:0]     pos10;
	logic [SCALED_W-1:0]     db10;
	logic [SCALED_W-1:0]     tgt10;

	always_comb begin
		st    = st_cur;
		idle  = idle_cur;
		pause = PAUSE_NONE;

		if (new_command) begin
			st.prev_mode = st.mode;
			st.mode      = command_code;
			idle         = '0;
			if (command_code == MODE_TRACK) begin
				st.target = target_elevation;
			end
		end else begin
			idle = idle + 1'b1;
			if (CMP_W'(idle) == CMP_W'(idle_timeout)) begin
				st.mode = MODE_SLEEP;
				idle    = '0;
			end
		end

		if (emergency_stop) begin
			st.relays = '0;
			st.mode   = MODE_SLEEP;
		end

		// Position is reading * 3.6; everything is scaled by ten to stay exact.
		pos10 = SCALED_W'(elevation_reading) * SCALED_W'(36);
		db10  = SCALED_W'(deadband) * SCALED_W'(10);
		tgt10 = SCALED_W'(st.target) * SCALED_W'(10);

		unique case (st.mode)
			MODE_CW: begin
				st.prev_mode = st.mode;
				if (st.relays[RB_CCW]) begin
					st.relays[RB_CCW] = 1'b0;
					pause = PAUSE_LONG;
				end
				st.relays[RB_CW] = 1'b1;
				st.mode = MODE_SLEEP;
			end
			MODE_CCW: begin
				st.prev_mode = st.mode;
				if (st.relays[RB_CW]) begin
					st.relays[RB_CW] = 1'b0;
					pause = PAUSE_LONG;
				end
				st.relays[RB_CCW] = 1'b1;
				st.mode = MODE_SLEEP;
			end
			MODE_STOP_AZ: begin
				st.prev_mode = st.mode;
				st.relays[RB_CW]  = 1'b0;
				st.relays[RB_CCW] = 1'b0;
				st.mode = MODE_SLEEP;
			end
			MODE_UP: begin
				st.prev_mode = st.mode;
				if (st.relays[RB_DOWN]) begin
					st.relays[RB_DOWN] = 1'b0;
					pause = PAUSE_LONG;
				end
				st.relays[RB_UP] = 1'b1;
				st.mode = MODE_SLEEP;
			end
			MODE_DOWN: begin
				st.prev_mode = st.mode;
				if (st.relays[RB_UP]) begin
					st.relays[RB_UP] = 1'b0;
					pause = PAUSE_LONG;
				end
				st.relays[RB_DOWN] = 1'b1;
				st.mode = MODE_SLEEP;
			end
			MODE_STOP_EL: begin
				st.prev_mode = st.mode;
				st.relays[RB_UP]   = 1'b0;
				st.relays[RB_DOWN] = 1'b0;
				st.mode = MODE_SLEEP;
			end
			MODE_STOP_ALL: begin
				st.prev_mode = st.mode;
				st.relays = '0;
				st.mode = MODE_SLEEP;
			end
			MODE_TRACK: begin
				// Entering tracking drops every relay before the first move.
				if (st.prev_mode != st.mode) begin
					st.prev_mode = st.mode;
					st.relays   = '0;
					pause       = PAUSE_LONG;
					st.tracking = 1'b1;
				end
				if (pos10 + db10 < tgt10) begin
					st.relays[RB_CCW] = 1'b0;
					st.relays[RB_CW]  = 1'b1;
				end else if (pos10 > tgt10 + db10) begin
					st.relays[RB_CW]  = 1'b0;
					st.relays[RB_CCW] = 1'b1;
				end else begin
					st.relays[RB_CW]  = 1'b0;
					st.relays[RB_CCW] = 1'b0;
					st.tracking = 1'b0;
					st.mode     = MODE_SLEEP;
				end
			end
			MODE_SLEEP: begin
				st.prev_mode = st.mode;
				pause = PAUSE_SHORT;
			end
			default: begin
				st.prev_mode = st.mode;
				st.mode = MODE_SLEEP;
			end
		endcase

		st_nxt       = st;
		idle_nxt     = idle;
		res.relays   = st.relays;
		res.mode     = st.mode;
		res.tracking = st.tracking;
		res.pause    = pause;
	end

endmodule

>>> rtl/rotator_relay_command_fsm_unit.sv
// A result is registered and shown in the cycle after its command beat is accepted.
// One beat per clock unless the output holds back; the only loop is the registered state update,
// and the one-entry result register takes a new beat whenever it is empty or drained.
// Reset (arst_n low, asynchronous): mode and previous mode go to sleep, all relays off,
// tracking and the latched target clear, the idle counter clears, and the timeout
// and deadband registers return to 100000 accepted beats and 100 position units.
module rotator_relay_command_fsm_unit import rrc_pkg::*; #(
	parameter int COUNTER_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rrc_in_if.sink                cmd,
	rrc_out_if.source             res
);

	rrc_state_t              st_q;
	rrc_state_t              st_nxt;
	logic [COUNTER_BITS-1:0] idle_q;
	logic [COUNTER_BITS-1:0] idle_nxt;
	logic [TIMEOUT_W-1:0]    idle_timeout_q;
	logic [DEADBAND_W-1:0]   deadband_q;
	rrc_result_t             step_res;
	rrc_result_t             res_s1;
	logic                    res_valid_s1;
	logic                    accept;

	assign cmd.ready = !res_valid_s1 || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	rrc_step #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_step (
		.st_cur            (st_q),
		.idle_cur          (idle_q),
		.idle_timeout      (idle_timeout_q),
		.deadband          (deadband_q),
		.new_command       (cmd.new_command),
		.command_code      (cmd.command_code),
		.target_elevation  (cmd.target_elevation),
		.emergency_stop    (cmd.emergency_stop),
		.elevation_reading (cmd.elevation_reading),
		.st_nxt            (st_nxt),
		.idle_nxt          (idle_nxt),
		.res               (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q <= IDLE_TIMEOUT_RST;
			deadband_q     <= DEADBAND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data[TIMEOUT_W-1:0];
				CFG_DEADBAND:     deadband_q     <= cfg_data[DEADBAND_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= '0;
			idle_q       <= '0;
			res_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				st_q   <= st_nxt;
				idle_q <= idle_nxt;
			end
			if (accept) begin
				res_valid_s1 <= 1'b1;
			end else if (res.ready) begin
				res_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= step_res;
		end
	end

	assign res.valid           = res_valid_s1;
	assign res.relay_cw        = res_s1.relays[RB_CW];
	assign res.relay_ccw       = res_s1.relays[RB_CCW];
	assign res.relay_up        = res_s1.relays[RB_UP];
	assign res.relay_down      = res_s1.relays[RB_DOWN];
	assign res.current_mode    = res_s1.mode;
	assign res.tracking_active = res_s1.tracking;
	assign res.pause_code      = res_s1.pause;

	// Every beat leaves the machine asleep or still tracking.
	a_mode_settled: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mode == MODE_SLEEP || st_q.mode == MODE_TRACK)
		else $error("stored mode is neither sleep nor track");

	a_az_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_q.relays[RB_CW] && st_q.relays[RB_CCW]))
		else $error("both azimuth relays energized");

	a_el_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_q.relays[RB_UP] && st_q.relays[RB_DOWN]))
		else $error("both elevation relays energized");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid_s1 && res_s1.pause != 2'd3)
		else $error("accepted beat did not produce a well-formed result");

endmodule
